### sv/text_glow_trail_renderer_core_assert.svh
// Assertion macros shared by the renderer RTL.
`ifndef TEXT_GLOW_TRAIL_RENDERER_CORE_ASSERT_SVH
`define TEXT_GLOW_TRAIL_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGTR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgtr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgtr assertion failed");

`endif

### sv/tgtr_pkg.sv
// ----------------------------------------------------------------------------
// tgtr_pkg
// Shared constants, register codes, divider handshake types and the color
// arithmetic of the glowing text trail renderer.
// ----------------------------------------------------------------------------
package tgtr_pkg;

    // Trail depth default.
    localparam int MAX_TRAIL_DEFAULT = 16;

    // Field widths.
    localparam int GLYPH_W = 8;
    localparam int POS_W   = 9;
    localparam int COORD_W = 8;
    localparam int RGB_W   = 24;
    localparam int LEN_W   = 5;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 24;
    localparam int T_W     = 17;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_ORIGIN_ROW    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_COLUMN = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOX_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_BOX_HEIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TRAIL_LENGTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEXT_RGB      = 3'd5;
    localparam logic [IDX_W-1:0] REG_GLOW_RGB      = 3'd6;
    localparam logic [IDX_W-1:0] REG_EFFECT_MODE   = 3'd7;

    // Register reset values.
    localparam logic [COORD_W-1:0] RST_ORIGIN_ROW    = 8'd0;
    localparam logic [COORD_W-1:0] RST_ORIGIN_COLUMN = 8'd1;
    localparam logic [COORD_W-1:0] RST_BOX_WIDTH     = 8'd80;
    localparam logic [COORD_W-1:0] RST_BOX_HEIGHT    = 8'd24;
    localparam logic [LEN_W-1:0]   RST_TRAIL_LENGTH  = 5'd5;
    localparam logic [RGB_W-1:0]   RST_TEXT_RGB      = 24'hFFFFFF;
    localparam logic [RGB_W-1:0]   RST_GLOW_RGB      = 24'hFF0000;

    // Command codes and special glyphs.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;
    localparam logic [GLYPH_W-1:0] GLYPH_NEWLINE = 8'd10;

    // Phase advance per shimmering redraw, Q0.16.
    localparam logic [15:0] PHASE_STEP = 16'd5243;

    // Divider operand widths.
    localparam int DVD_W = 17;
    localparam int DSR_W = 16;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

    // Blend a toward b by t, where t = 65536 means fully b.
    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [T_W-1:0] t);
        logic signed [9:0]  diff;
        logic signed [27:0] prod;
        logic signed [27:0] v;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        prod = diff * $signed({1'b0, t});
        v    = $signed({4'b0000, a, 16'h0000}) + prod;
        return v[23:16];
    endfunction

    // Dark version of a glow channel.
    function automatic logic [7:0] dark(input logic [7:0] c);
        return {2'b00, c[7:2]};
    endfunction

    // Bright version of a glow channel: c + 3(255 - c)/4.
    function automatic logic [7:0] bright(input logic [7:0] c);
        logic [9:0] x;
        x = 10'd3 * {2'b00, 8'd255 - c};
        return c + x[9:2];
    endfunction

    // Triangle wave of the phase, 0 .. 65536.
    function automatic logic [T_W-1:0] wave(input logic [15:0] p);
        logic [17:0] w;
        if (p[15] == 1'b0)
        begin
            w = {1'b0, p, 1'b0};
        end
        else
        begin
            w = 18'h20000 - {1'b0, p, 1'b0};
        end
        return w[T_W-1:0];
    endfunction

endpackage

### sv/tgtr_if.sv
// ----------------------------------------------------------------------------
// tgtr channel interfaces
// Valid/ready channels for input items, draw commands and register writes.
// ----------------------------------------------------------------------------
interface tgtr_char_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [tgtr_pkg::GLYPH_W-1:0] glyph;

    modport source (output valid, cmd, glyph, input ready);
    modport sink (input valid, cmd, glyph, output ready);
endinterface

interface tgtr_draw_if;
    logic                          valid;
    logic                          ready;
    logic [tgtr_pkg::POS_W-1:0]   draw_row;
    logic [tgtr_pkg::POS_W-1:0]   draw_column;
    logic [tgtr_pkg::GLYPH_W-1:0] draw_glyph;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic                          last_of_run;

    modport source (output valid, draw_row, draw_column, draw_glyph, red, green, blue,
                    last_of_run, input ready);
    modport sink (input valid, draw_row, draw_column, draw_glyph, red, green, blue,
                  last_of_run, output ready);
endinterface

interface tgtr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tgtr_pkg::IDX_W-1:0]  index;
    logic [tgtr_pkg::DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/tgtr_ram.sv
// ----------------------------------------------------------------------------
// tgtr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tgtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### sv/tgtr_div.sv
// ----------------------------------------------------------------------------
// tgtr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgtr_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tgtr_pkg::div_req_t req,
    output tgtr_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(tgtr_pkg::DVD_W + 1);

    logic [tgtr_pkg::DVD_W-1:0] dvd_reg;
    logic [tgtr_pkg::DSR_W-1:0] dsr_reg;
    logic [tgtr_pkg::DSR_W-1:0] part_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [tgtr_pkg::DSR_W:0]   trial;
    logic                       fits;

    // Shift in the next dividend bit and compare with the divisor.
    always_comb
    begin
        trial = {part_reg, dvd_reg[tgtr_pkg::DVD_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            part_reg <= '0;
        end
        else if (req.start)
        begin
            dvd_reg  <= req.dividend;
            dsr_reg  <= req.divisor;
            part_reg <= '0;
            cnt_reg  <= CNT_W'(tgtr_pkg::DVD_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                part_reg <= tgtr_pkg::DSR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                part_reg <= trial[tgtr_pkg::DSR_W-1:0];
            end
            dvd_reg <= {dvd_reg[tgtr_pkg::DVD_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = part_reg;

endmodule

### sv/text_glow_trail_renderer_core.sv
// ----------------------------------------------------------------------------
// text_glow_trail_renderer_core
// Places characters in a text box and redraws a shaded glow trail of the
// most recent glyphs for every character.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                     transaction
//  char_in   in         cmd, glyph                                  one item
//  draw_out  out        draw_row, draw_column, draw_glyph, rgb,     one draw
//                       last_of_run
//  cfg       in         index, data                                 one write
//
// Cursor normalization takes two divider passes, then a trail push adds a
// step division when n > 1. The walk back steps the draw position back one
// glyph at a time, and each draw passes through S_RD, S_MIX1 and S_MIX2.
// A stalled draw_out holds the sequencer in its final blend stage; the output
// register lets a new item start while the last draw waits.
// Reset is asynchronous; the trail memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "text_glow_trail_renderer_core_assert.svh"

module text_glow_trail_renderer_core #(
    parameter int MAX_TRAIL = tgtr_pkg::MAX_TRAIL_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    tgtr_char_if.sink     char_in,
    tgtr_draw_if.source   draw_out,
    tgtr_cfg_if.sink      cfg
);

    localparam int CW = $clog2(MAX_TRAIL + 1);
    localparam int AW = (MAX_TRAIL > 1) ? $clog2(MAX_TRAIL) : 1;
    localparam int LW = (CW > tgtr_pkg::LEN_W) ? CW : tgtr_pkg::LEN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DMOD, S_DROW, S_PUSH, S_TDIV, S_BACK, S_RD, S_MIX1, S_MIX2
    } state_t;

    // Configuration registers.
    logic [7:0]                  origin_row_reg, origin_column_reg;
    logic [7:0]                  box_width_reg, box_height_reg;
    logic [tgtr_pkg::LEN_W-1:0]  trail_length_reg;
    logic [23:0]                 text_rgb_reg, glow_rgb_reg;
    logic                        effect_mode_reg;

    // Sequencer state.
    state_t                      state_reg;
    logic                        cmd_reg;
    logic [7:0]                  glyph_in_reg;
    logic [7:0]                  cur_row_reg, cur_col_reg;
    logic [7:0]                  pos_row_reg, pos_col_reg;
    logic [AW-1:0]               head_reg;
    logic [CW-1:0]               count_reg, n_reg, j_reg, steps_reg, trem_reg;
    logic [15:0]                 phase_reg;
    logic [tgtr_pkg::T_W-1:0]    t_reg, tq_reg;
    logic                        text_only_reg, use_in_reg;
    logic [7:0]                  glyph_reg;
    logic [23:0]                 inner_reg;
    tgtr_pkg::div_req_t          div_req_reg;
    tgtr_pkg::div_rsp_t          div_rsp;

    // Output register.
    logic                        out_valid_reg;
    logic [8:0]                  out_row_reg, out_col_reg;
    logic [7:0]                  out_glyph_reg, out_red_reg, out_green_reg, out_blue_reg;
    logic                        out_last_reg;

    // Trail memory ports.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [7:0]                  ram_rdata;

    // Combinational helpers.
    logic [7:0]                  w_eff, h_eff;
    logic [CW-1:0]               len_eff, keep_cnt, drop_cnt;
    logic [AW-1:0]               new_head;
    logic [LW-1:0]               tl_ext;
    logic                        out_free;
    logic                        out_load;
    logic                        div_start;
    logic [CW:0]                 trem_sum;
    logic [7:0]                  glyph_sel;
    logic [23:0]                 inner_next, color_next;
    logic [tgtr_pkg::T_W-1:0]    wave_t;

    // Add modulo the trail depth; both operands stay below twice the depth.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(MAX_TRAIL))
        begin
            s = s - (CW+1)'(MAX_TRAIL);
        end
        return AW'(s);
    endfunction

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_row_reg    <= tgtr_pkg::RST_ORIGIN_ROW;
            origin_column_reg <= tgtr_pkg::RST_ORIGIN_COLUMN;
            box_width_reg     <= tgtr_pkg::RST_BOX_WIDTH;
            box_height_reg    <= tgtr_pkg::RST_BOX_HEIGHT;
            trail_length_reg  <= tgtr_pkg::RST_TRAIL_LENGTH;
            text_rgb_reg      <= tgtr_pkg::RST_TEXT_RGB;
            glow_rgb_reg      <= tgtr_pkg::RST_GLOW_RGB;
            effect_mode_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tgtr_pkg::REG_ORIGIN_ROW:    origin_row_reg    <= cfg.data[7:0];
                tgtr_pkg::REG_ORIGIN_COLUMN: origin_column_reg <= cfg.data[7:0];
                tgtr_pkg::REG_BOX_WIDTH:     box_width_reg     <= cfg.data[7:0];
                tgtr_pkg::REG_BOX_HEIGHT:    box_height_reg    <= cfg.data[7:0];
                tgtr_pkg::REG_TRAIL_LENGTH:  trail_length_reg  <= cfg.data[tgtr_pkg::LEN_W-1:0];
                tgtr_pkg::REG_TEXT_RGB:      text_rgb_reg      <= cfg.data;
                tgtr_pkg::REG_GLOW_RGB:      glow_rgb_reg      <= cfg.data;
                tgtr_pkg::REG_EFFECT_MODE:   effect_mode_reg   <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Effective box size and trail length, and the trail push bookkeeping.
    always_comb
    begin
        w_eff  = (box_width_reg == 8'd0) ? 8'd1 : box_width_reg;
        h_eff  = (box_height_reg == 8'd0) ? 8'd1 : box_height_reg;
        tl_ext = LW'(trail_length_reg);
        if (tl_ext > LW'(MAX_TRAIL))
        begin
            len_eff = CW'(MAX_TRAIL);
        end
        else
        begin
            len_eff = CW'(tl_ext);
        end
        if ((count_reg >= len_eff) && (len_eff != '0))
        begin
            drop_cnt = count_reg - len_eff + CW'(1);
            keep_cnt = len_eff - CW'(1);
        end
        else
        begin
            drop_cnt = '0;
            keep_cnt = count_reg;
        end
        new_head = wrap_add(head_reg, drop_cnt);
        out_free = !out_valid_reg || draw_out.ready;
        trem_sum = {1'b0, trem_reg} + {1'b0, div_rsp.remainder[CW-1:0]};
    end

    // Output load and divider start requests of the sequencer.
    assign out_load  = (state_reg == S_MIX2) && out_free;
    assign div_start = ((state_reg == S_IDLE) && char_in.valid) ||
                       ((state_reg == S_DMOD) && div_rsp.done) ||
                       ((state_reg == S_PUSH) && (keep_cnt != '0));

    // First blend stage: glyph select and glow color, shimmering or plain.
    always_comb
    begin
        glyph_sel = use_in_reg ? glyph_in_reg : ram_rdata;
        wave_t    = tgtr_pkg::wave(phase_reg + t_reg[15:0]);
        for (int k = 0; k < 3; k++)
        begin
            if (effect_mode_reg)
            begin
                inner_next[8*k +: 8] = tgtr_pkg::mix(tgtr_pkg::dark(glow_rgb_reg[8*k +: 8]),
                                                     tgtr_pkg::bright(glow_rgb_reg[8*k +: 8]),
                                                     wave_t);
            end
            else
            begin
                inner_next[8*k +: 8] = glow_rgb_reg[8*k +: 8];
            end
        end
    end

    // Second blend stage: text color toward the glow color, or plain text color.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (text_only_reg)
            begin
                color_next[8*k +: 8] = text_rgb_reg[8*k +: 8];
            end
            else
            begin
                color_next[8*k +: 8] = tgtr_pkg::mix(text_rgb_reg[8*k +: 8],
                                                     inner_reg[8*k +: 8], t_reg);
            end
        end
    end

    // Trail memory access.
    assign ram_we    = (state_reg == S_PUSH);
    assign ram_waddr = wrap_add(new_head, keep_cnt);
    assign ram_raddr = wrap_add(head_reg, j_reg);

    tgtr_ram #(
        .WIDTH (tgtr_pkg::GLYPH_W),
        .DEPTH (MAX_TRAIL)
    ) u_trail_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (glyph_in_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tgtr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign char_in.ready = (state_reg == S_IDLE);

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= tgtr_pkg::CMD_CHAR;
            glyph_in_reg  <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            steps_reg     <= '0;
            trem_reg      <= '0;
            phase_reg     <= '0;
            t_reg         <= '0;
            tq_reg        <= '0;
            text_only_reg <= 1'b0;
            use_in_reg    <= 1'b0;
            glyph_reg     <= '0;
            inner_reg     <= '0;
            div_req_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_glyph_reg <= '0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= div_start;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (draw_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (char_in.valid)
                    begin
                        cmd_reg              <= char_in.cmd;
                        glyph_in_reg         <= char_in.glyph;
                        div_req_reg.dividend <= tgtr_pkg::DVD_W'(16'(cur_row_reg * w_eff)
                                                + 16'(cur_col_reg));
                        div_req_reg.divisor  <= 16'(h_eff * w_eff);
                        state_reg            <= S_DMOD;
                    end
                end

                S_DMOD:
                begin
                    if (div_rsp.done)
                    begin
                        div_req_reg.dividend <= tgtr_pkg::DVD_W'(div_rsp.remainder);
                        div_req_reg.divisor  <= 16'(w_eff);
                        state_reg            <= S_DROW;
                    end
                end

                S_DROW:
                begin
                    if (div_rsp.done)
                    begin
                        pos_row_reg <= div_rsp.quotient[7:0];
                        pos_col_reg <= div_rsp.remainder[7:0];
                        j_reg       <= '0;
                        t_reg       <= '0;
                        trem_reg    <= '0;
                        if (cmd_reg == tgtr_pkg::CMD_END)
                        begin
                            n_reg         <= count_reg;
                            steps_reg     <= count_reg;
                            text_only_reg <= 1'b1;
                            use_in_reg    <= 1'b0;
                            if (count_reg == '0)
                            begin
                                cur_row_reg <= '0;
                                cur_col_reg <= '0;
                                phase_reg   <= '0;
                                state_reg   <= S_IDLE;
                            end
                            else
                            begin
                                cur_row_reg <= div_rsp.quotient[7:0];
                                cur_col_reg <= div_rsp.remainder[7:0];
                                state_reg   <= S_BACK;
                            end
                        end
                        else if (glyph_in_reg == tgtr_pkg::GLYPH_NEWLINE)
                        begin
                            count_reg   <= '0;
                            cur_col_reg <= '0;
                            if (8'(div_rsp.quotient[7:0] + 8'd1) == h_eff)
                            begin
                                cur_row_reg <= '0;
                            end
                            else
                            begin
                                cur_row_reg <= div_rsp.quotient[7:0] + 8'd1;
                            end
                            state_reg <= S_IDLE;
                        end
                        else if (len_eff == '0)
                        begin
                            cur_row_reg   <= div_rsp.quotient[7:0];
                            cur_col_reg   <= div_rsp.remainder[7:0];
                            n_reg         <= CW'(1);
                            steps_reg     <= '0;
                            text_only_reg <= 1'b1;
                            use_in_reg    <= 1'b1;
                            state_reg     <= S_BACK;
                        end
                        else
                        begin
                            cur_row_reg <= div_rsp.quotient[7:0];
                            cur_col_reg <= div_rsp.remainder[7:0];
                            state_reg   <= S_PUSH;
                        end
                    end
                end

                S_PUSH:
                begin
                    head_reg      <= new_head;
                    count_reg     <= keep_cnt + CW'(1);
                    n_reg         <= keep_cnt + CW'(1);
                    steps_reg     <= keep_cnt;
                    text_only_reg <= 1'b0;
                    use_in_reg    <= 1'b0;
                    tq_reg        <= '0;
                    if (keep_cnt != '0)
                    begin
                        div_req_reg.dividend <= tgtr_pkg::DVD_W'(17'h10000);
                        div_req_reg.divisor  <= 16'(keep_cnt);
                        state_reg            <= S_TDIV;
                    end
                    else
                    begin
                        state_reg <= S_BACK;
                    end
                end

                S_TDIV:
                begin
                    if (div_rsp.done)
                    begin
                        tq_reg    <= div_rsp.quotient;
                        state_reg <= S_BACK;
                    end
                end

                S_BACK:
                begin
                    // Walk the draw position back to the oldest trail glyph.
                    if (steps_reg == '0)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        steps_reg <= steps_reg - CW'(1);
                        if (pos_col_reg == 8'd0)
                        begin
                            pos_col_reg <= w_eff - 8'd1;
                            pos_row_reg <= (pos_row_reg == 8'd0) ? (h_eff - 8'd1)
                                                                 : (pos_row_reg - 8'd1);
                        end
                        else
                        begin
                            pos_col_reg <= pos_col_reg - 8'd1;
                        end
                    end
                end

                S_RD:
                begin
                    state_reg <= S_MIX1;
                end

                S_MIX1:
                begin
                    glyph_reg <= glyph_sel;
                    inner_reg <= inner_next;
                    state_reg <= S_MIX2;
                end

                S_MIX2:
                begin
                    if (out_free)
                    begin
                        out_row_reg   <= 9'(origin_row_reg) + 9'(pos_row_reg);
                        out_col_reg   <= 9'(origin_column_reg) + 9'(pos_col_reg);
                        out_glyph_reg <= glyph_reg;
                        out_red_reg   <= color_next[23:16];
                        out_green_reg <= color_next[15:8];
                        out_blue_reg  <= color_next[7:0];
                        out_last_reg  <= (j_reg + CW'(1) == n_reg);
                        if (j_reg + CW'(1) == n_reg)
                        begin
                            // Last draw: settle cursor, trail and phase.
                            if (cmd_reg == tgtr_pkg::CMD_END)
                            begin
                                cur_row_reg <= '0;
                                cur_col_reg <= '0;
                                count_reg   <= '0;
                                phase_reg   <= '0;
                            end
                            else
                            begin
                                if (cur_col_reg + 8'd1 == w_eff)
                                begin
                                    cur_col_reg <= '0;
                                    cur_row_reg <= (cur_row_reg + 8'd1 == h_eff) ? 8'd0
                                                                                 : (cur_row_reg + 8'd1);
                                end
                                else
                                begin
                                    cur_col_reg <= cur_col_reg + 8'd1;
                                end
                                if (!text_only_reg && effect_mode_reg)
                                begin
                                    phase_reg <= phase_reg + tgtr_pkg::PHASE_STEP;
                                end
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg <= j_reg + CW'(1);
                            if (pos_col_reg + 8'd1 == w_eff)
                            begin
                                pos_col_reg <= '0;
                                pos_row_reg <= (pos_row_reg + 8'd1 == h_eff) ? 8'd0
                                                                             : (pos_row_reg + 8'd1);
                            end
                            else
                            begin
                                pos_col_reg <= pos_col_reg + 8'd1;
                            end
                            // Exact step of t = j * 65536 / (n - 1).
                            if (trem_sum >= {1'b0, n_reg - CW'(1)})
                            begin
                                trem_reg <= CW'(trem_sum - {1'b0, n_reg - CW'(1)});
                                t_reg    <= t_reg + tq_reg + tgtr_pkg::T_W'(1);
                            end
                            else
                            begin
                                trem_reg <= CW'(trem_sum);
                                t_reg    <= t_reg + tq_reg;
                            end
                            state_reg <= S_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output channel.
    assign draw_out.valid       = out_valid_reg;
    assign draw_out.draw_row    = out_row_reg;
    assign draw_out.draw_column = out_col_reg;
    assign draw_out.draw_glyph  = out_glyph_reg;
    assign draw_out.red         = out_red_reg;
    assign draw_out.green       = out_green_reg;
    assign draw_out.blue        = out_blue_reg;
    assign draw_out.last_of_run = out_last_reg;

    // Checks on the trail bookkeeping and the sequencer.
    `TGTR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_TRAIL))
    `TGTR_ASSERT_IMP(a_draw_index, state_reg == S_RD, j_reg < n_reg)
    `TGTR_ASSERT_NEXT(a_accept_busy, char_in.valid && char_in.ready, state_reg == S_DMOD)
    `TGTR_ASSERT_IMP(a_push_room, state_reg == S_PUSH, keep_cnt < len_eff)

endmodule

### sim/text_glow_trail_renderer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glow_trail_renderer_core_test
// Self-checking bench for the glow trail renderer. A shading predictor tracks
// cursor, trail and shimmer phase, and every draw transaction is compared
// against the oldest predicted draw. Both channels idle at random, and the
// register setup changes between phases, including the extreme settings.
// ----------------------------------------------------------------------------
module text_glow_trail_renderer_core_test;

    localparam int TRAIL_DEPTH = tgtr_pkg::MAX_TRAIL_DEFAULT;
    localparam int CYCLE_LIMIT = 900000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       glyph;
    } char_item_t;

    typedef struct packed {
        logic [8:0] row;
        logic [8:0] column;
        logic [7:0] glyph;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } draw_t;

    logic clk;
    logic rst_n;

    tgtr_char_if char_in ();
    tgtr_draw_if draw_out ();
    tgtr_cfg_if  cfg ();

    text_glow_trail_renderer_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .draw_out (draw_out),
        .cfg      (cfg)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the registers.
    logic [7:0]  sh_origin_row;
    logic [7:0]  sh_origin_column;
    logic [7:0]  sh_box_width;
    logic [7:0]  sh_box_height;
    logic [4:0]  sh_trail_length;
    logic [23:0] sh_text_rgb;
    logic [23:0] sh_glow_rgb;
    logic        sh_shimmer;

    // Shadow copy of the renderer state.
    int          cur_row;
    int          cur_column;
    logic [7:0]  trail_mem [TRAIL_DEPTH];
    int          trail_count;
    logic [15:0] phase;

    char_item_t  pending_chars [$];
    draw_t       expected_draws [$];
    int          mismatches;
    int          cycle_count;
    bit          sender_idles;
    bit          receiver_idles;
    bit          long_hold;
    bit          char_taken;
    bit          draw_taken;
    int          send_gap;
    int          recv_gap;

    function automatic int box_w();
        return (sh_box_width == 0) ? 1 : int'(sh_box_width);
    endfunction

    function automatic int box_h();
        return (sh_box_height == 0) ? 1 : int'(sh_box_height);
    endfunction

    function automatic int channel(input logic [23:0] rgb, input int k);
        return int'((rgb >> (16 - 8 * k)) & 24'hFF);
    endfunction

    // Blend a toward b by t in Q0.16, with 65536 meaning fully b.
    function automatic int blend(input int a, input int b, input int t);
        longint v;
        v = longint'(a) * 65536 + longint'(b - a) * longint'(t);
        if (v < 0)
        begin
            v = 0;
        end
        return int'((v >> 16) & 255);
    endfunction

    function automatic void place_cursor(input int idx);
        int total;
        total = box_w() * box_h();
        idx = idx % total;
        cur_row = idx / box_w();
        cur_column = idx % box_w();
    endfunction

    function automatic void push_draw(input int idx, input logic [7:0] g, input int r,
                                      input int gr, input int b, input bit last);
        draw_t d;
        d.row = 9'((int'(sh_origin_row) + idx / box_w()) & 511);
        d.column = 9'((int'(sh_origin_column) + idx % box_w()) & 511);
        d.glyph = g;
        d.red = 8'(r);
        d.green = 8'(gr);
        d.blue = 8'(b);
        d.last = last;
        expected_draws.insert(expected_draws.size(), d);
    endfunction

    // Works out the draws of one accepted item and advances the shadow state.
    function automatic void predict_draws(input char_item_t it);
        int total;
        int cur;
        int len;
        int n;
        int drop;
        int t;
        int p;
        int wv;
        int col [3];
        int gc;
        total = box_w() * box_h();
        cur = (cur_row * box_w() + cur_column) % total;
        if (it.cmd == tgtr_pkg::CMD_END)
        begin
            n = trail_count;
            for (int j = 0; j < n; j++)
            begin
                push_draw((cur + total * (TRAIL_DEPTH + 1) - n + j) % total, trail_mem[j],
                          channel(sh_text_rgb, 0), channel(sh_text_rgb, 1),
                          channel(sh_text_rgb, 2), j + 1 == n);
            end
            cur_row = 0;
            cur_column = 0;
            trail_count = 0;
            phase = 16'd0;
            return;
        end
        if (it.glyph == tgtr_pkg::GLYPH_NEWLINE)
        begin
            trail_count = 0;
            place_cursor((cur / box_w() + 1) * box_w());
            return;
        end
        len = (sh_trail_length > TRAIL_DEPTH) ? TRAIL_DEPTH : int'(sh_trail_length);
        if (len == 0)
        begin
            push_draw(cur, it.glyph, channel(sh_text_rgb, 0), channel(sh_text_rgb, 1),
                      channel(sh_text_rgb, 2), 1'b1);
            place_cursor(cur + 1);
            return;
        end
        if (trail_count >= len)
        begin
            drop = trail_count - (len - 1);
            for (int i = 0; i + 1 < len; i++)
            begin
                trail_mem[i] = trail_mem[i + drop];
            end
            trail_count = len - 1;
        end
        trail_mem[trail_count] = it.glyph;
        trail_count++;
        n = trail_count;
        for (int j = 0; j < n; j++)
        begin
            t = (n == 1) ? 0 : int'((longint'(j) << 16) / (n - 1));
            p = (int'(phase) + t) & 16'hFFFF;
            wv = (p < 32768) ? 2 * p : 131072 - 2 * p;
            for (int k = 0; k < 3; k++)
            begin
                gc = channel(sh_glow_rgb, k);
                if (sh_shimmer)
                begin
                    gc = blend(gc >> 2, gc + (3 * (255 - gc)) / 4, wv);
                end
                col[k] = blend(channel(sh_text_rgb, k), gc, t);
            end
            push_draw((cur + total * (TRAIL_DEPTH + 1) - n + 1 + j) % total, trail_mem[j],
                      col[0], col[1], col[2], j + 1 == n);
        end
        if (sh_shimmer)
        begin
            phase = phase + tgtr_pkg::PHASE_STEP;
        end
        place_cursor(cur + 1);
    endfunction

    // Register write, applied to the shadow copy at the accepting edge.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
            begin
                break;
            end
        end
        case (idx)
            tgtr_pkg::REG_ORIGIN_ROW:    sh_origin_row = value[7:0];
            tgtr_pkg::REG_ORIGIN_COLUMN: sh_origin_column = value[7:0];
            tgtr_pkg::REG_BOX_WIDTH:     sh_box_width = value[7:0];
            tgtr_pkg::REG_BOX_HEIGHT:    sh_box_height = value[7:0];
            tgtr_pkg::REG_TRAIL_LENGTH:  sh_trail_length = value[4:0];
            tgtr_pkg::REG_TEXT_RGB:      sh_text_rgb = value;
            tgtr_pkg::REG_GLOW_RGB:      sh_glow_rgb = value;
            tgtr_pkg::REG_EFFECT_MODE:   sh_shimmer = value[0];
            default:                     ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic setup_box(input logic [23:0] orow, input logic [23:0] ocol,
                             input logic [23:0] w, input logic [23:0] h,
                             input logic [23:0] len, input logic [23:0] txt,
                             input logic [23:0] glow, input logic [23:0] mode);
        write_reg(tgtr_pkg::REG_ORIGIN_ROW, orow);
        write_reg(tgtr_pkg::REG_ORIGIN_COLUMN, ocol);
        write_reg(tgtr_pkg::REG_BOX_WIDTH, w);
        write_reg(tgtr_pkg::REG_BOX_HEIGHT, h);
        write_reg(tgtr_pkg::REG_TRAIL_LENGTH, len);
        write_reg(tgtr_pkg::REG_TEXT_RGB, txt);
        write_reg(tgtr_pkg::REG_GLOW_RGB, glow);
        write_reg(tgtr_pkg::REG_EFFECT_MODE, mode);
    endtask

    task automatic queue_char(input logic cmd, input logic [7:0] g);
        char_item_t it;
        it.cmd = cmd;
        it.glyph = g;
        pending_chars.insert(pending_chars.size(), it);
    endtask

    // Mostly characters, with some newlines and end-of-text items.
    task automatic queue_random_text(input int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                queue_char(tgtr_pkg::CMD_END, 8'($urandom));
            end
            else if (roll < 15)
            begin
                queue_char(tgtr_pkg::CMD_CHAR, tgtr_pkg::GLYPH_NEWLINE);
            end
            else
            begin
                queue_char(tgtr_pkg::CMD_CHAR, 8'($urandom));
            end
        end
    endtask

    // Waits until every item is taken and every draw has arrived.
    task automatic drain();
        wait (pending_chars.size() == 0 && !char_in.valid && expected_draws.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Item driver: changes inputs at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!char_in.valid || char_taken))
        begin
            if (char_taken)
            begin
                char_taken = 1'b0;
                send_gap = sender_idles ? $urandom_range(0, 17) : 0;
            end
            if (send_gap > 0)
            begin
                send_gap--;
                char_in.valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                char_in.cmd <= pending_chars[0].cmd;
                char_in.glyph <= pending_chars[0].glyph;
                pending_chars.delete(0);
                char_in.valid <= 1'b1;
            end
            else
            begin
                char_in.valid <= 1'b0;
            end
        end
    end

    // Item acceptance feeds the predictor.
    always @(posedge clk)
    begin
        char_item_t it;
        if (rst_n && char_in.valid && char_in.ready)
        begin
            it.cmd = char_in.cmd;
            it.glyph = char_in.glyph;
            predict_draws(it);
            char_taken = 1'b1;
        end
    end

    // Draw receiver ready, with random gaps and the long hold-off.
    always @(negedge clk)
    begin
        if (draw_taken)
        begin
            draw_taken = 1'b0;
            recv_gap = receiver_idles ? $urandom_range(0, 17) : 0;
        end
        if (recv_gap > 0)
        begin
            recv_gap--;
            draw_out.ready <= 1'b0;
        end
        else
        begin
            draw_out.ready <= !long_hold;
        end
    end

    // Draw monitor: compares every transaction with the oldest prediction.
    always @(posedge clk)
    begin
        draw_t got;
        draw_t want;
        if (rst_n && draw_out.valid && draw_out.ready)
        begin
            draw_taken = 1'b1;
            got.row = draw_out.draw_row;
            got.column = draw_out.draw_column;
            got.glyph = draw_out.draw_glyph;
            got.red = draw_out.red;
            got.green = draw_out.green;
            got.blue = draw_out.blue;
            got.last = draw_out.last_of_run;
            if (expected_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected draw row %0d col %0d glyph %0h", got.row,
                             got.column, got.glyph);
                end
            end
            else
            begin
                want = expected_draws[0];
                expected_draws.delete(0);
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("draw mismatch: expected row %0d col %0d glyph %h rgb %h%h%h %b",
                                 want.row, want.column, want.glyph, want.red, want.green,
                                 want.blue, want.last);
                        $display("                 actual row %0d col %0d glyph %h rgb %h%h%h %b",
                                 got.row, got.column, got.glyph, got.red, got.green,
                                 got.blue, got.last);
                    end
                end
            end
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial
    begin
        long_hold = 1'b0;
        wait (rst_n && sh_trail_length == 5'd16 && sh_shimmer);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (700) @(negedge clk);
        long_hold = 1'b0;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("text_glow_trail_renderer_core_test: FAIL");
            $finish;
        end
    end

    // Reset, register phases and stimulus.
    initial
    begin
        rst_n = 1'b0;
        char_in.valid = 1'b0;
        char_in.cmd = tgtr_pkg::CMD_CHAR;
        char_in.glyph = 8'd0;
        draw_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = tgtr_pkg::REG_ORIGIN_ROW;
        cfg.data = 24'd0;
        char_taken = 1'b0;
        draw_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        mismatches = 0;
        cycle_count = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        sh_origin_row = tgtr_pkg::RST_ORIGIN_ROW;
        sh_origin_column = tgtr_pkg::RST_ORIGIN_COLUMN;
        sh_box_width = tgtr_pkg::RST_BOX_WIDTH;
        sh_box_height = tgtr_pkg::RST_BOX_HEIGHT;
        sh_trail_length = tgtr_pkg::RST_TRAIL_LENGTH;
        sh_text_rgb = tgtr_pkg::RST_TEXT_RGB;
        sh_glow_rgb = tgtr_pkg::RST_GLOW_RGB;
        sh_shimmer = 1'b0;
        cur_row = 0;
        cur_column = 0;
        trail_count = 0;
        phase = 16'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: end with an empty trail, glyph extremes, trail overflow,
        // newline and end of text.
        queue_char(tgtr_pkg::CMD_END, 8'hFF);
        queue_char(tgtr_pkg::CMD_CHAR, 8'h00);
        queue_char(tgtr_pkg::CMD_CHAR, 8'hFF);
        for (int i = 0; i < 6; i++)
        begin
            queue_char(tgtr_pkg::CMD_CHAR, 8'h41 + 8'(i));
        end
        queue_char(tgtr_pkg::CMD_CHAR, tgtr_pkg::GLYPH_NEWLINE);
        queue_char(tgtr_pkg::CMD_CHAR, 8'h5A);
        queue_char(tgtr_pkg::CMD_CHAR, 8'h7E);
        queue_char(tgtr_pkg::CMD_END, 8'h00);
        drain();

        // Zero box size with the glow off.
        setup_box(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h000000, 24'hFFFFFF, 24'd0);
        queue_char(tgtr_pkg::CMD_CHAR, 8'h31);
        queue_char(tgtr_pkg::CMD_CHAR, tgtr_pkg::GLYPH_NEWLINE);
        queue_char(tgtr_pkg::CMD_CHAR, 8'h32);
        queue_char(tgtr_pkg::CMD_END, 8'h00);
        drain();

        // Largest box, longest trail, shimmer, under receiver back-pressure.
        sender_idles = 1'b0;
        setup_box(24'hFF, 24'hFF, 24'hFF, 24'hFF, 24'd16, 24'hFFFFFF, 24'h000000, 24'd1);
        queue_random_text(20);
        drain();
        sender_idles = 1'b1;

        // Trail length beyond the depth saturates; the box shrinks under the cursor.
        setup_box(24'd3, 24'd7, 24'd0, 24'd3, 24'd31, 24'h123456, 24'hFEDCBA, 24'd1);
        queue_random_text(15);
        drain();

        // Random settings, with idling switched per phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            sender_idles = (ph % 3 != 1);
            receiver_idles = (ph % 4 != 2);
            write_reg(tgtr_pkg::REG_ORIGIN_ROW, 24'($urandom));
            write_reg(tgtr_pkg::REG_ORIGIN_COLUMN, 24'($urandom));
            write_reg(tgtr_pkg::REG_BOX_WIDTH, 24'($urandom_range(0, 12)));
            write_reg(tgtr_pkg::REG_BOX_HEIGHT, 24'($urandom_range(0, 6)));
            write_reg(tgtr_pkg::REG_TRAIL_LENGTH, 24'($urandom_range(0, 31)));
            write_reg(tgtr_pkg::REG_TEXT_RGB, 24'($urandom));
            write_reg(tgtr_pkg::REG_GLOW_RGB, 24'($urandom));
            write_reg(tgtr_pkg::REG_EFFECT_MODE, 24'($urandom));
            queue_random_text(24);
            drain();
        end

        if (mismatches == 0 && expected_draws.size() == 0)
        begin
            $display("text_glow_trail_renderer_core_test: PASS");
        end
        else
        begin
            $display("text_glow_trail_renderer_core_test: FAIL");
        end
        $finish;
    end

endmodule
